/* sv/mitd_pkg.sv */
// ----------------------------------------------------------------------------
// mitd_pkg: shared definitions for the integrate-and-dump threshold detector
// Widths, register indexes, reset values and the types passed between the
// lanes, the merging stage and the top level.
// ----------------------------------------------------------------------------
package mitd_pkg;

    // Lanes actually built; the ports always carry MAX_CH channels
    localparam int CHANNELS   = 8;
    localparam int MAX_CH     = 8;

    localparam int SAMPLE_W   = 8;
    localparam int SUM_W      = 18;
    localparam int CNT_W      = 10;
    localparam int MASK_W     = MAX_CH;
    localparam int CHG_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 18;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(1);

    // Register reset values
    localparam logic [CNT_W-1:0] WINDOW_RST    = CNT_W'(50);
    localparam logic [SUM_W-1:0] THRESHOLD_RST = SUM_W'(800);

    // Per-request control for every lane
    typedef struct packed {
        logic add;   // good request accepted: add the sample
        logic dump;  // window completes: clear the sum
    } t_lane_ctrl;

    // One finished window
    typedef struct packed {
        logic [MAX_CH-1:0][SUM_W-1:0] total;
        logic [MASK_W-1:0]            mask;
        logic                         changed;
        logic [CHG_W-1:0]             count;
    } t_result;

endpackage

/* sv/mitd_lane.sv */
// ----------------------------------------------------------------------------
// mitd_lane: one channel accumulator with threshold compare
// Adds the sample of each good request to the running sum, reports the sum
// including this request and whether it lies above the threshold.
// ----------------------------------------------------------------------------
module mitd_lane
    import mitd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lane_ctrl          i_ctrl,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SUM_W-1:0]    i_threshold,
    output logic [SUM_W-1:0]    o_total,
    output logic                o_active
);

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic [SUM_W:0]   sum_wide;
    logic [SUM_W-1:0] sum_sat;

    // Add the sample, saturate at the top of the range
    always_comb begin
        sum_wide = {1'b0, r_sum} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, i_sample};
        sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    end

    assign o_total  = sum_sat;
    assign o_active = (sum_sat > i_threshold);

    // Clear on dump, advance on a good request, hold otherwise
    always_comb begin
        n_sum = r_sum;
        if (i_ctrl.dump) begin
            n_sum = '0;
        end else if (i_ctrl.add) begin
            n_sum = sum_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

endmodule

/* sv/mitd_merge.sv */
// ----------------------------------------------------------------------------
// mitd_merge: mask tracking and result buffer
// Compares the lanes' active mask against the stored mask, counts changes and
// holds finished windows in an output register with one skid entry.
// ----------------------------------------------------------------------------
module mitd_merge
    import mitd_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [MAX_CH-1:0][SUM_W-1:0] i_total,
    input  logic [MASK_W-1:0]            i_mask,
    input  logic                         i_stall,
    output logic                         o_valid,
    output t_result                      o_result,
    output logic                         o_full
);

    logic [MASK_W-1:0] r_mask;
    logic [MASK_W-1:0] n_mask;
    logic [CHG_W-1:0]  r_changes;
    logic [CHG_W-1:0]  n_changes;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_skid_valid;
    logic              n_skid_valid;
    t_result           r_out;
    t_result           n_out;
    t_result           r_skid;
    t_result           n_skid;
    t_result           new_res;
    logic              differs;
    logic              take;

    // Build the new result from the lanes and the mask history
    always_comb begin
        differs           = (i_mask != r_mask);
        new_res.total     = i_total;
        new_res.mask      = i_mask;
        new_res.changed   = differs;
        new_res.count     = differs ? (r_changes + CHG_W'(1)) : r_changes;
        n_mask            = (i_push && differs) ? i_mask : r_mask;
        n_changes         = i_push ? new_res.count : r_changes;
    end

    assign take = r_out_valid && !i_stall;

    // Drain into the output register, park in the skid entry while stalled
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (take || !r_out_valid) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out        = new_res;
                n_out_valid  = 1'b1;
            end else begin
                n_out_valid  = 1'b0;
            end
        end else if (i_push) begin
            n_skid       = new_res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask       <= '0;
            r_changes    <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_mask       <= n_mask;
            r_changes    <= n_changes;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;
    assign o_full   = r_skid_valid;

    // A parked result always has one ahead of it
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // No new result may arrive while the skid entry is occupied
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_valid)
        else $error("result pushed into full buffer");

    // The change counter moves by one exactly when a changed window is pushed
    a_change_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && differs) |=> (r_changes == $past(r_changes) + CHG_W'(1)))
        else $error("change counter did not advance");

    // Without a push, the mask history holds
    a_history_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_push |=> ($stable(r_mask) && $stable(r_changes)))
        else $error("mask history changed without a result");

endmodule

/* sv/multichannel_integrate_threshold_detect.sv */
// ----------------------------------------------------------------------------
// multichannel_integrate_threshold_detect: windowed per-channel threshold detector
// Sums eight channels over a window of good packets and flags active channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one request per packet, eight 8-bit
//   samples plus i_packet_good. Bad packets are dropped with no effect.
//   Output channel (o_valid / i_stall): one request per finished window with
//   eight totals, the active mask, the change flag and the change count.
//   Config channel (i_cfg_valid / o_cfg_ready): index 0 is the window length
//   (0 acts as 1), index 1 the threshold; ready is always high. Write only
//   while no window is in flight.
//   Throughput: one packet per cycle while o_stall is low; the eight lane
//   adders and compares run in parallel. A window's result is registered,
//   when its last packet is accepted, into the output register or the skid entry.
//   Stall: the output register plus one skid entry keep packets flowing while
//   a result waits; o_stall rises only when both hold a result.
//   Reset: sums, packet count, stored mask and change counter clear; window
//   length returns to 50 and threshold to 800.
// ----------------------------------------------------------------------------
module multichannel_integrate_threshold_detect
    import mitd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // packet channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_packet_good,
    input  logic [SAMPLE_W-1:0]   i_sample_ch0,
    input  logic [SAMPLE_W-1:0]   i_sample_ch1,
    input  logic [SAMPLE_W-1:0]   i_sample_ch2,
    input  logic [SAMPLE_W-1:0]   i_sample_ch3,
    input  logic [SAMPLE_W-1:0]   i_sample_ch4,
    input  logic [SAMPLE_W-1:0]   i_sample_ch5,
    input  logic [SAMPLE_W-1:0]   i_sample_ch6,
    input  logic [SAMPLE_W-1:0]   i_sample_ch7,
    // result channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SUM_W-1:0]      o_total_ch0,
    output logic [SUM_W-1:0]      o_total_ch1,
    output logic [SUM_W-1:0]      o_total_ch2,
    output logic [SUM_W-1:0]      o_total_ch3,
    output logic [SUM_W-1:0]      o_total_ch4,
    output logic [SUM_W-1:0]      o_total_ch5,
    output logic [SUM_W-1:0]      o_total_ch6,
    output logic [SUM_W-1:0]      o_total_ch7,
    output logic [MASK_W-1:0]     o_active_mask,
    output logic                  o_mask_changed,
    output logic [CHG_W-1:0]      o_change_count,
    // configuration channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CNT_W-1:0]             r_window;
    logic [CNT_W-1:0]             n_window;
    logic [SUM_W-1:0]             r_threshold;
    logic [SUM_W-1:0]             n_threshold;
    logic [CNT_W-1:0]             r_count;
    logic [CNT_W-1:0]             n_count;
    logic [CNT_W-1:0]             count_inc;
    logic [CNT_W-1:0]             win_eff;
    logic                         accept;
    logic                         good;
    logic                         dump;
    logic                         full;
    t_lane_ctrl                   lane_ctrl;
    logic [MAX_CH-1:0][SAMPLE_W-1:0] samples;
    logic [MAX_CH-1:0][SUM_W-1:0] totals;
    logic [MASK_W-1:0]            mask;
    t_result                      result;

    assign samples = {i_sample_ch7, i_sample_ch6, i_sample_ch5, i_sample_ch4,
                      i_sample_ch3, i_sample_ch2, i_sample_ch1, i_sample_ch0};

    // Handshake: stall only when the result buffer is full
    assign o_stall = full;
    assign accept  = i_valid && !full;
    assign good    = accept && i_packet_good;

    // Packet count and window end
    always_comb begin
        count_inc = (r_count < CNT_MAX) ? (r_count + CNT_W'(1)) : r_count;
        win_eff   = (r_window == '0) ? CNT_W'(1) : r_window;
        dump      = good && (count_inc >= win_eff);
        n_count   = r_count;
        if (dump) begin
            n_count = '0;
        end else if (good) begin
            n_count = count_inc;
        end
    end

    assign lane_ctrl.add  = good;
    assign lane_ctrl.dump = dump;

    // Configuration decode
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_window    = r_window;
        n_threshold = r_threshold;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_WINDOW:    n_window    = i_cfg_data[CNT_W-1:0];
                REG_THRESHOLD: n_threshold = i_cfg_data[SUM_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window    <= WINDOW_RST;
            r_threshold <= THRESHOLD_RST;
            r_count     <= '0;
        end else begin
            r_window    <= n_window;
            r_threshold <= n_threshold;
            r_count     <= n_count;
        end
    end

    // Lanes; unused channels report zero and stay inactive
    for (genvar g = 0; g < MAX_CH; g++) begin : g_lane
        if (g < CHANNELS) begin : g_used
            mitd_lane u_lane (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctrl      (lane_ctrl),
                .i_sample    (samples[g]),
                .i_threshold (r_threshold),
                .o_total     (totals[g]),
                .o_active    (mask[g])
            );
        end else begin : g_unused
            assign totals[g] = '0;
            assign mask[g]   = 1'b0;
        end
    end

    mitd_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (dump),
        .i_total  (totals),
        .i_mask   (mask),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_result (result),
        .o_full   (full)
    );

    assign o_total_ch0    = result.total[0];
    assign o_total_ch1    = result.total[1];
    assign o_total_ch2    = result.total[2];
    assign o_total_ch3    = result.total[3];
    assign o_total_ch4    = result.total[4];
    assign o_total_ch5    = result.total[5];
    assign o_total_ch6    = result.total[6];
    assign o_total_ch7    = result.total[7];
    assign o_active_mask  = result.mask;
    assign o_mask_changed = result.changed;
    assign o_change_count = result.count;

endmodule
